// File: rtl/rlng_pkg.sv
`default_nettype none

package rlng_pkg;

    // Field widths
    localparam int SEQ_W       = 16;
    localparam int MASK_BITS   = 16;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 4;
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    // Default depth of the received map (a power of two, 64 to 32768)
    localparam int WINDOW_DEF = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [LEN_W-1:0] MIN_BATCH_RST = 5'd8;
    localparam logic [CNT_W-1:0] MAX_NACKS_RST = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BATCH = 1'b0,
        CFG_MAX_NACKS = 1'b1
    } t_cfg_idx;

    // One generic NACK entry before its run flags are known
    typedef struct packed {
        logic [SEQ_W-1:0]     pid;
        logic [MASK_BITS-1:0] mask;
        logic [LEN_W-1:0]     len;
    } t_nack;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_EVAL,
        ST_DUP,
        ST_PFX,
        ST_PFX_CHK,
        ST_NK_CHECK,
        ST_SCAN,
        ST_SCAN_END,
        ST_POST,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/rlng_in_if.sv
`default_nettype none

interface rlng_in_if;
    import rlng_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_num;
    logic             is_retransmit;

    modport source (output valid, output seq_num, output is_retransmit, input ready);
    modport sink   (input valid, input seq_num, input is_retransmit, output ready);
endinterface

`default_nettype wire

// File: rtl/rlng_out_if.sv
`default_nettype none

interface rlng_out_if;
    import rlng_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SEQ_W-1:0]     lost_pid;
    logic [MASK_BITS-1:0] lost_mask;
    logic [LEN_W-1:0]     mask_len;
    logic                 out_of_window;
    logic                 last_of_run;

    modport source (output valid, output lost_pid, output lost_mask, output mask_len,
                    output out_of_window, output last_of_run, input ready);
    modport sink   (input valid, input lost_pid, input lost_mask, input mask_len,
                    input out_of_window, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/rlng_map_ram.sv
`default_nettype none

// One-bit-wide received map with one write port and one registered read port.
// A read and a write to the same entry in one cycle return the old value.
module rlng_map_ram #(
    parameter int AW = 10
) (
    input  wire          i_clk,
    input  wire          i_we,
    input  wire [AW-1:0] i_waddr,
    input  wire          i_wdata,
    input  wire [AW-1:0] i_raddr,
    output logic         o_rdata
);
    logic r_mem [2**AW];

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// File: rtl/rlng_res_buf.sv
`default_nettype none

// Holds the NACK entries of one run until the run's flags are known.
module rlng_res_buf (
    input  wire                            i_clk,
    input  wire                            i_we,
    input  wire [rlng_pkg::RES_IDX_W-1:0]  i_widx,
    input  rlng_pkg::t_nack                i_wdata,
    input  wire [rlng_pkg::RES_IDX_W-1:0]  i_ridx,
    output rlng_pkg::t_nack                o_rdata
);
    import rlng_pkg::*;

    t_nack r_buf [MAX_RESULTS];

    // Entry write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_buf[i_widx] <= i_wdata;
        end
    end

    assign o_rdata = r_buf[i_ridx];
endmodule

`default_nettype wire

// File: rtl/rtp_loss_nack_generator_core.sv
`default_nettype none

// RTP loss tracker that emits generic NACK entries. Each received sequence number
// is checked against a base number and a received map of WINDOW bits held in a
// single-port-write, registered-read memory; the block walks that memory one bit
// per cycle. One transaction is handled at a time: it is classified, the base moves
// over the in-order numbers, a NACK entry is built per missing stretch, and each
// result is handed to the output register. A full run holds up to 8 entries.
// After reset the map is cleared before the first transaction is taken;
// configuration writes are taken at any time.
// WINDOW must be a power of two.
module rtp_loss_nack_generator_core #(
    parameter int WINDOW = rlng_pkg::WINDOW_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [rlng_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [rlng_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rlng_in_if.sink                        i_in,
    rlng_out_if.source                     o_out
);
    import rlng_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam logic [SEQ_W:0] WIN_EXT  = (SEQ_W+1)'(WINDOW);
    localparam logic [SEQ_W:0] WRAP_LIM = (SEQ_W+1)'(65535 - WINDOW);

    t_state r_state, n_state;

    logic                 r_started, n_started;
    logic [SEQ_W-1:0]     r_base, n_base;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_high, n_high;
    logic [SEQ_W-1:0]     r_seq, n_seq;
    logic                 r_rtx, n_rtx;
    logic [SEQ_W-1:0]     r_target, n_target;
    logic                 r_flush, n_flush;
    logic                 r_wrap, n_wrap;
    logic                 r_oow, n_oow;
    logic [AW-1:0]        r_d, n_d;
    logic [CNT_W-1:0]     r_budget, n_budget;
    logic [LEN_W-1:0]     r_cnt, n_cnt;
    logic [LEN_W-1:0]     r_j, n_j;
    logic [LEN_W-1:0]     r_jd, n_jd;
    logic                 r_jdv, n_jdv;
    logic [MASK_BITS-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [AW-1:0]        r_clr, n_clr;
    logic [LEN_W-1:0]     r_min_batch;
    logic [CNT_W-1:0]     r_max_nacks;

    logic                 r_out_valid, n_out_valid;
    t_nack                r_out_nack, n_out_nack;
    logic                 r_out_oow, n_out_oow;
    logic                 r_out_last, n_out_last;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_rdata;

    logic                 buf_we;
    t_nack                buf_wdata;
    t_nack                buf_rdata;

    logic [SEQ_W-1:0]     d_full;
    logic                 d_ok;
    logic                 d_oow;
    logic [AW-1:0]        d_slot;
    logic                 is_wrap;
    logic [SEQ_W-1:0]     gap;
    logic [LEN_W-1:0]     nk_cnt;
    logic [LEN_W-1:0]     batch;
    logic [CNT_W-1:0]     budget_init;
    logic                 nk_stop;
    logic                 nk_small;
    logic                 scan_last;
    logic                 out_free;
    logic                 k_last;
    logic [LEN_W-1:0]     adv_k;
    logic                 in_acc;

    rlng_map_ram #(.AW(AW)) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rlng_res_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_widx  (r_n[RES_IDX_W-1:0]),
        .i_wdata (buf_wdata),
        .i_ridx  (r_k[RES_IDX_W-1:0]),
        .o_rdata (buf_rdata)
    );

    // Shared decode of the current transaction and the NACK loop
    assign d_full      = r_seq - r_base;
    assign d_ok        = (d_full != '0) && !d_full[SEQ_W-1];
    assign d_oow       = {1'b0, d_full} >= WIN_EXT;
    assign d_slot      = r_head + d_full[AW-1:0];
    assign is_wrap     = (r_seq < r_base) && (r_base != 16'hFFFF) &&
                         ({1'b0, r_seq} < WIN_EXT) && ({1'b0, r_base} > WRAP_LIM);
    assign gap         = r_target - r_base - 16'd1;
    assign nk_cnt      = (gap < 16'(MASK_BITS)) ? gap[LEN_W-1:0] : LEN_W'(MASK_BITS);
    assign batch       = (r_min_batch > LEN_W'(MASK_BITS)) ? LEN_W'(MASK_BITS) : r_min_batch;
    assign budget_init = (r_max_nacks > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                             : r_max_nacks;
    assign nk_stop     = (r_base == r_target) || (r_budget == '0);
    assign nk_small    = !r_flush && (nk_cnt < batch);
    assign scan_last   = (r_j == r_cnt + 5'd1);
    assign out_free    = !r_out_valid || o_out.ready;
    assign k_last      = (r_k + 4'd1 == r_n);
    assign adv_k       = r_cnt + 5'd1;
    assign in_acc      = i_in.valid && i_in.ready;

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.lost_pid      = r_out_nack.pid;
    assign o_out.lost_mask     = r_out_nack.mask;
    assign o_out.mask_len      = r_out_nack.len;
    assign o_out.out_of_window = r_out_oow;
    assign o_out.last_of_run   = r_out_last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (is_wrap)               n_state = ST_PFX;
                else if (r_rtx || !d_ok)   n_state = ST_IDLE;
                else if (d_oow)            n_state = ST_OUT;
                else                       n_state = ST_DUP;
            end
            ST_DUP: begin
                n_state = mem_rdata ? ST_IDLE : ST_PFX;
            end
            ST_PFX: begin
                n_state = (r_high != '0) ? ST_PFX_CHK : ST_NK_CHECK;
            end
            ST_PFX_CHK: begin
                if (!(mem_rdata && (r_high != AW'(1)))) n_state = ST_NK_CHECK;
            end
            ST_NK_CHECK: begin
                if (nk_stop || nk_small) n_state = r_wrap ? ST_POST : ST_OUT;
                else                     n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                n_state = ST_NK_CHECK;
            end
            ST_POST: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (r_n == '0 && !r_oow) begin
                    n_state = ST_IDLE;
                end else if (out_free && (r_n == '0 || k_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result loading
    always_comb begin
        n_started   = r_started;
        n_base      = r_base;
        n_head      = r_head;
        n_high      = r_high;
        n_seq       = r_seq;
        n_rtx       = r_rtx;
        n_target    = r_target;
        n_flush     = r_flush;
        n_wrap      = r_wrap;
        n_oow       = r_oow;
        n_d         = r_d;
        n_budget    = r_budget;
        n_cnt       = r_cnt;
        n_j         = r_j;
        n_jd        = r_jd;
        n_jdv       = 1'b0;
        n_n         = r_n;
        n_k         = r_k;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_nack  = r_out_nack;
        n_out_oow   = r_out_oow;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_head + AW'(1);
        mem_wdata   = 1'b0;
        mem_raddr   = r_head + AW'(1);
        buf_we      = 1'b0;
        buf_wdata   = '{pid: r_base + 16'd1, mask: '0, len: r_cnt};

        // Gather the mask bit read in the previous cycle
        n_mask = r_mask;
        if (r_jdv && r_jd >= 5'd2) begin
            n_mask = r_mask | (MASK_BITS'(mem_rdata) << (r_jd - 5'd2));
        end

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_seq  = i_in.seq_num;
                    n_rtx  = i_in.is_retransmit;
                    n_n    = '0;
                    n_k    = '0;
                    n_oow  = 1'b0;
                    n_wrap = 1'b0;
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_base    = i_in.seq_num - 16'd1;
                    end
                end
            end
            ST_EVAL: begin
                // Look up the entry for a duplicate check
                mem_raddr = d_slot;
                n_d       = d_full[AW-1:0];
                if (is_wrap) begin
                    n_flush  = 1'b1;
                    n_wrap   = 1'b1;
                    n_target = 16'hFFFF;
                end else if (!r_rtx && d_ok && d_oow) begin
                    n_oow = 1'b1;
                end
            end
            ST_DUP: begin
                if (!mem_rdata) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_head + r_d;
                    mem_wdata = 1'b1;
                    n_flush   = 1'b0;
                    if (r_d > r_high) begin
                        n_high   = r_d;
                        n_target = r_base + 16'(r_d);
                    end else begin
                        n_target = r_base + 16'(r_high);
                    end
                end
            end
            ST_PFX: begin
                n_budget = budget_init;
            end
            ST_PFX_CHK: begin
                // Move the base over a received number and look at the next one
                if (mem_rdata) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_head + AW'(1);
                    mem_raddr = r_head + AW'(2);
                    n_head    = r_head + AW'(1);
                    n_base    = r_base + 16'd1;
                    n_high    = r_high - AW'(1);
                end
            end
            ST_NK_CHECK: begin
                if (!nk_stop) begin
                    n_budget = r_budget - 4'd1;
                    n_cnt    = nk_cnt;
                    n_j      = 5'd1;
                    n_mask   = '0;
                end
            end
            ST_SCAN: begin
                // Read each passed bit and clear it in the same cycle
                mem_raddr = r_head + AW'(r_j);
                mem_we    = 1'b1;
                mem_waddr = r_head + AW'(r_j);
                n_jd      = r_j;
                n_jdv     = 1'b1;
                n_j       = r_j + 5'd1;
            end
            ST_SCAN_END: begin
                buf_we         = 1'b1;
                buf_wdata.mask = ~n_mask & ((MASK_BITS'(1) << r_cnt) - MASK_BITS'(1));
                if (r_cnt == LEN_W'(MASK_BITS)) begin
                    buf_wdata.mask = ~n_mask;
                end
                n_n    = r_n + 4'd1;
                n_head = r_head + AW'(adv_k);
                n_base = r_base + 16'(adv_k);
                n_high = (r_high > AW'(adv_k)) ? r_high - AW'(adv_k) : '0;
            end
            ST_POST: begin
                // Record the number that caused the flush at its new offset, or flag it as out of window
                if (d_ok) begin
                    if (d_oow) begin
                        n_oow = 1'b1;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = d_slot;
                        mem_wdata = 1'b1;
                        if (d_full[AW-1:0] > r_high) n_high = d_full[AW-1:0];
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    if (r_n == '0) begin
                        if (r_oow) begin
                            n_out_valid = 1'b1;
                            n_out_nack  = '0;
                            n_out_oow   = 1'b1;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_nack  = buf_rdata;
                        n_out_oow   = r_oow;
                        n_out_last  = k_last;
                        n_k         = r_k + 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_started   <= 1'b0;
            r_base      <= '0;
            r_head      <= '0;
            r_high      <= '0;
            r_clr       <= '0;
            r_jdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_base      <= n_base;
            r_head      <= n_head;
            r_high      <= n_high;
            r_clr       <= n_clr;
            r_jdv       <= n_jdv;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_batch <= MIN_BATCH_RST;
            r_max_nacks <= MAX_NACKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MIN_BATCH) r_min_batch <= i_cfg_data[LEN_W-1:0];
            if (i_cfg_idx == CFG_MAX_NACKS) r_max_nacks <= i_cfg_data[CNT_W-1:0];
        end
    end

    // Working registers of the current transaction
    always_ff @(posedge i_clk) begin
        r_seq      <= n_seq;
        r_rtx      <= n_rtx;
        r_target   <= n_target;
        r_flush    <= n_flush;
        r_wrap     <= n_wrap;
        r_oow      <= n_oow;
        r_d        <= n_d;
        r_budget   <= n_budget;
        r_cnt      <= n_cnt;
        r_j        <= n_j;
        r_jd       <= n_jd;
        r_mask     <= n_mask;
        r_n        <= n_n;
        r_k        <= n_k;
        r_out_nack <= n_out_nack;
        r_out_oow  <= n_out_oow;
        r_out_last <= n_out_last;
    end
endmodule

`default_nettype wire
